// File: hw/rtl/vac_pkg.sv
// ----------------------------------------------------------------------------
// vac_pkg: shared types and constants for the vertex attribute converter
// Request/result payloads, format codes and the stage-to-stage structs.
// ----------------------------------------------------------------------------
package vac_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFormat    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegNormalize = 4'd1;

  // component formats
  localparam logic [3:0] FmtS8     = 4'd0;
  localparam logic [3:0] FmtU8     = 4'd1;
  localparam logic [3:0] FmtS16    = 4'd2;
  localparam logic [3:0] FmtU16    = 4'd3;
  localparam logic [3:0] FmtHalf   = 4'd4;
  localparam logic [3:0] FmtFloat  = 4'd5;
  localparam logic [3:0] FmtS32    = 4'd6;
  localparam logic [3:0] FmtU32    = 4'd7;
  localparam logic [3:0] FmtDouble = 4'd8;

  // datapath routes
  localparam logic [1:0] PathDirect = 2'd0;
  localparam logic [1:0] PathInt    = 2'd1;
  localparam logic [1:0] PathNrm    = 2'd2;
  localparam logic [1:0] PathDbl    = 2'd3;

  // repeat period of m/(2^n-1)
  localparam logic [1:0] Per7  = 2'd0;
  localparam logic [1:0] Per8  = 2'd1;
  localparam logic [1:0] Per15 = 2'd2;
  localparam logic [1:0] Per16 = 2'd3;

  localparam logic [31:0] FpOne = 32'h3F80_0000;
  localparam logic [31:0] FpInf = 32'h7F80_0000;
  localparam logic [31:0] FpQnan = 32'h7FC0_0000;

  typedef struct packed {
    logic [63:0] component_bits;
    logic        last_in_row;
  } vac_in_t;

  typedef struct packed {
    logic [31:0] float_bits;
    logic        row_end;
  } vac_out_t;

  typedef struct packed {
    logic [1:0]        path;
    logic              sign;
    logic [52:0]       mag;
    logic signed [9:0] eadj;
    logic [1:0]        period;
    logic [31:0]       direct;
    logic              last;
  } vac_dec_t;

  typedef struct packed {
    logic        is_direct;
    logic [31:0] direct;
    logic        sign;
    logic [30:0] base;
    logic        guard;
    logic        sticky;
    logic        ovf_chk;
    logic        last;
  } vac_aln_t;

endpackage

// File: hw/rtl/vac_decode.sv
// ----------------------------------------------------------------------------
// vac_decode: stage 1, format decode
// Extracts sign and magnitude per format, resolves special values directly.
// ----------------------------------------------------------------------------
module vac_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  vac_pkg::vac_in_t req_i,
  input  logic [3:0]       fmt_i,
  input  logic             nrm_i,
  output logic             valid_o,
  output vac_pkg::vac_dec_t dec_o
);
  import vac_pkg::*;

  logic        valid_q;
  vac_dec_t    dec_d, dec_q;

  logic [63:0] raw;
  logic        w16, sgn_f, neg;
  logic [15:0] bits16;
  logic [16:0] m17, lim;
  logic [31:0] u32;
  logic [10:0] dex;
  logic signed [11:0] fe;

  assign raw = req_i.component_bits;

  always_comb begin
    dec_d        = '0;
    dec_d.last   = req_i.last_in_row;
    dec_d.path   = PathDirect;
    w16    = (fmt_i == FmtS16) || (fmt_i == FmtU16);
    sgn_f  = (fmt_i == FmtS8) || (fmt_i == FmtS16);
    bits16 = w16 ? raw[15:0] : {8'h00, raw[7:0]};
    neg    = sgn_f & (w16 ? raw[15] : raw[7]);
    m17    = neg ? ((w16 ? 17'h1_0000 : 17'h0_0100) - {1'b0, bits16}) : {1'b0, bits16};
    lim    = w16 ? (sgn_f ? 17'd32767 : 17'd65535) : (sgn_f ? 17'd127 : 17'd255);
    u32    = raw[31:0];
    dex    = raw[62:52];
    fe     = $signed({1'b0, dex}) - 12'sd896;
    unique case (fmt_i) inside
      FmtS8, FmtU8, FmtS16, FmtU16: begin
        dec_d.sign = neg;
        dec_d.mag  = {36'b0, m17};
        if (!nrm_i) begin
          dec_d.path = PathInt;
        end else if (m17 == '0) begin
          dec_d.direct = '0;
        end else if (m17 >= lim) begin
          // full scale, negative extreme clamps to -1.0
          dec_d.direct = {neg, FpOne[30:0]};
        end else begin
          dec_d.path   = PathNrm;
          dec_d.period = w16 ? (sgn_f ? Per15 : Per16) : (sgn_f ? Per7 : Per8);
        end
      end
      FmtHalf: begin
        if (raw[14:10] == 5'h1F) begin
          dec_d.direct = {raw[15], FpInf[30:0]} | {9'b0, raw[9:0], 13'b0};
        end else begin
          dec_d.path = PathInt;
          dec_d.sign = raw[15];
          if (raw[14:10] == 5'h00) begin
            dec_d.mag  = {43'b0, raw[9:0]};
            dec_d.eadj = -10'sd24;
          end else begin
            dec_d.mag  = {42'b0, 1'b1, raw[9:0]};
            dec_d.eadj = $signed({5'b0, raw[14:10]}) - 10'sd25;
          end
        end
      end
      FmtFloat: dec_d.direct = u32;
      FmtS32, FmtU32: begin
        dec_d.path = PathInt;
        dec_d.sign = (fmt_i == FmtS32) & u32[31];
        dec_d.mag  = {21'b0, (dec_d.sign ? 32'(-u32) : u32)};
        if (nrm_i) dec_d.eadj = (fmt_i == FmtS32) ? -10'sd31 : -10'sd32;
      end
      FmtDouble: begin
        dec_d.sign = raw[63];
        if (dex == 11'h7FF) begin
          dec_d.direct = (raw[51:0] == '0) ? {raw[63], FpInf[30:0]}
                       : ({raw[63], FpQnan[30:0]} | {9'b0, raw[51:29]});
        end else if (dex == '0 || fe < -12'sd24) begin
          dec_d.direct = {raw[63], 31'b0};
        end else if (fe > 12'sd254) begin
          dec_d.direct = {raw[63], FpInf[30:0]};
        end else begin
          dec_d.path = PathDbl;
          dec_d.mag  = {1'b1, raw[51:0]};
          dec_d.eadj = 10'(fe);
        end
      end
      default: dec_d.direct = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) dec_q <= dec_d;
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// File: hw/rtl/vac_align.sv
// ----------------------------------------------------------------------------
// vac_align: stage 2, normalize and align
// Leading-zero count and shift; produces pre-round word, guard and sticky.
// ----------------------------------------------------------------------------
module vac_align (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vac_pkg::vac_dec_t dec_i,
  output logic              valid_o,
  output vac_pkg::vac_aln_t aln_o
);
  import vac_pkg::*;

  function automatic logic [4:0] lzc32(logic [31:0] x);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) c = 5'(31 - i);
    end
    return c;
  endfunction

  function automatic logic [3:0] lzc16(logic [15:0] x);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) c = 4'(15 - i);
    end
    return c;
  endfunction

  logic        valid_q;
  vac_aln_t    aln_d, aln_q;

  logic [4:0]  lz32;
  logic [31:0] norm32;
  logic [3:0]  lz16, lzn;
  logic [47:0] pat, pat_sh;
  logic [15:0] m16;
  logic [52:0] sig;
  logic [5:0]  dsh;
  logic [107:0] dx;
  logic signed [9:0] ex, exm1;

  always_comb begin
    aln_d           = '0;
    aln_d.last      = dec_i.last;
    aln_d.sign      = dec_i.sign;
    aln_d.direct    = dec_i.direct;
    aln_d.is_direct = (dec_i.path == PathDirect);
    lz32   = lzc32(dec_i.mag[31:0]);
    norm32 = dec_i.mag[31:0] << lz32;
    m16    = dec_i.mag[15:0];
    lz16   = lzc16(m16);
    pat    = '0;
    lzn    = lz16;
    sig    = dec_i.mag;
    dsh    = 6'd29;
    dx     = '0;
    ex     = '0;
    exm1   = '0;
    pat_sh = '0;
    unique case (dec_i.path)
      PathInt: begin
        ex   = 10'sd158 - $signed({5'b0, lz32}) + dec_i.eadj;
        exm1 = ex - 10'sd1;
        if (dec_i.mag[31:0] != '0) begin
          aln_d.base   = {exm1[7:0], 23'b0} + {7'b0, norm32[31:8]};
          aln_d.guard  = norm32[7];
          aln_d.sticky = |norm32[6:0];
        end
      end
      PathNrm: begin
        // m/(2^n-1) is the n-bit block of m repeated forever
        unique case (dec_i.period)
          Per7:    begin pat = {{6{m16[6:0]}}, 6'b0};  lzn = lz16 - 4'd9; end
          Per8:    begin pat = {6{m16[7:0]}};          lzn = lz16 - 4'd8; end
          Per15:   begin pat = {{3{m16[14:0]}}, 3'b0}; lzn = lz16 - 4'd1; end
          default: begin pat = {3{m16}};               lzn = lz16;        end
        endcase
        pat_sh       = pat << lzn;
        ex           = 10'sd126 - $signed({6'b0, lzn});
        exm1         = ex - 10'sd1;
        aln_d.base   = {exm1[7:0], 23'b0} + {7'b0, pat_sh[47:24]};
        aln_d.guard  = pat_sh[23];
        aln_d.sticky = 1'b1;
      end
      PathDbl: begin
        exm1 = dec_i.eadj - 10'sd1;
        dsh  = (dec_i.eadj >= 10'sd1) ? 6'd29 : 6'(10'sd30 - dec_i.eadj);
        dx   = {sig, 55'b0} >> dsh;
        aln_d.base    = (dec_i.eadj >= 10'sd1)
                      ? ({exm1[7:0], 23'b0} + {7'b0, dx[78:55]})
                      : {7'b0, dx[78:55]};
        aln_d.guard   = dx[54];
        aln_d.sticky  = |dx[53:0];
        aln_d.ovf_chk = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) aln_q <= aln_d;
  end

  assign valid_o = valid_q;
  assign aln_o   = aln_q;

endmodule

// File: hw/rtl/vac_round.sv
// ----------------------------------------------------------------------------
// vac_round: stage 3, round to nearest even and pack
// Adds the round bit, saturates double-path results to infinity, registers the result.
// ----------------------------------------------------------------------------
module vac_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vac_pkg::vac_aln_t aln_i,
  output logic              valid_o,
  output vac_pkg::vac_out_t rsp_o
);
  import vac_pkg::*;

  logic        valid_q;
  vac_out_t    rsp_d, rsp_q;
  logic        inc;
  logic [31:0] r;

  always_comb begin
    inc = aln_i.guard & (aln_i.sticky | aln_i.base[0]);
    // carry out of the mantissa bumps the exponent for free
    r   = {1'b0, aln_i.base} + {31'b0, inc};
    if (aln_i.ovf_chk && r >= FpInf) r = FpInf;
    rsp_d.row_end    = aln_i.last;
    rsp_d.float_bits = aln_i.is_direct ? aln_i.direct : {aln_i.sign, r[30:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// File: hw/rtl/vertex_attribute_convert.sv
// ----------------------------------------------------------------------------
// vertex_attribute_convert: vertex attribute component to fp32
// Three-stage pipeline: decode, normalize/align, round/pack.
// ----------------------------------------------------------------------------
// channel   | signals                              | transfer
// request   | start, busy, req_i                   | start & !busy
// result    | valid_o, rsp_o                       | valid_o, one cycle
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | valid & ready
//
// One request per cycle; each result passes through the decode, align and round registers.
// busy is never raised and cfg_ready_o is always high.
// Reset clears the stage valid bits; format resets to float, normalize off.
// Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module vertex_attribute_convert (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  vac_pkg::vac_in_t                  req_i,
  output logic                              valid_o,
  output vac_pkg::vac_out_t                 rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vac_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [vac_pkg::CfgDataW-1:0]      cfg_data_i
);
  import vac_pkg::*;

  logic [3:0] fmt_q;
  logic       nrm_q;
  logic       v1, v2;
  vac_dec_t   dec;
  vac_aln_t   aln;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtFloat;
      nrm_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegFormat)    fmt_q <= cfg_data_i[3:0];
      if (cfg_index_i == RegNormalize) nrm_q <= cfg_data_i[0];
    end
  end

  vac_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .req_i      (req_i),
    .fmt_i      (fmt_q),
    .nrm_i      (nrm_q),
    .valid_o    (v1),
    .dec_o      (dec)
  );

  vac_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .dec_i   (dec),
    .valid_o (v2),
    .aln_o   (aln)
  );

  vac_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .aln_i   (aln),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

// File: hw/rtl/vac_checker.sv
// ----------------------------------------------------------------------------
// vac_checker: port-level checks for the converter
// Fixed latency between request and result, row mark carried along.
// ----------------------------------------------------------------------------
module vac_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input vac_pkg::vac_in_t  req_i,
  input logic              valid_o,
  input vac_pkg::vac_out_t rsp_o
);
  import vac_pkg::*;

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 valid_o)
    else $error("request produced no result");

  a_result_had_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 3))
    else $error("result without request");

  a_row_end_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.row_end == $past(req_i.last_in_row, 3)))
    else $error("row mark lost");

endmodule

bind vertex_attribute_convert vac_checker u_vac_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .req_i   (req_i),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);

// File: sim/vertex_attribute_convert_test.sv
// ----------------------------------------------------------------------------
// vertex_attribute_convert_test: self-checking bench for the fp32 converter
// Drives components under every format and normalize setting, predicts each
// fp32 pattern with exact integer arithmetic and checks every result in order.
// ----------------------------------------------------------------------------
module vertex_attribute_convert_test;
  import vac_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [3:0]  FmtUnsupported = 4'd9;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 4'd2;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  vac_in_t             req_i = '0;
  logic                valid_o;
  vac_out_t            rsp_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [3:0] fmt_reg;
  logic       nrm_reg;
  vac_out_t   pending_q[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  vertex_attribute_convert uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .valid_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // value = m * 2^scale, rounded to nearest even; sticky_in marks a dropped tail
  function automatic logic [31:0] round_pack(logic s, logic [127:0] m, int scale,
                                             logic sticky_in);
    int p;
    int e;
    logic [127:0] t;
    logic [24:0] man;
    logic g;
    logic st;
    if (m == '0) return {s, 31'b0};
    p = 127;
    while (!m[p]) p--;
    if (p <= 23) begin
      t = m << (23 - p);
      man = t[24:0];
      g = 1'b0;
      st = sticky_in;
    end else begin
      t = m >> (p - 24);
      man = {1'b0, t[24:1]};
      g = t[0];
      st = sticky_in | ((m & ((128'b1 << (p - 24)) - 1)) != '0);
    end
    if (g && (st || man[0])) man = man + 25'd1;
    e = p + scale;
    if (man[24]) begin
      man = man >> 1;
      e++;
    end
    return {s, 8'(e + 127), man[22:0]};
  endfunction

  function automatic logic [31:0] div_round(logic s, logic [127:0] m, logic [127:0] d);
    logic [127:0] num;
    num = m << 48;
    return round_pack(s, num / d, -48, (num % d) != '0);
  endfunction

  function automatic logic [31:0] half_to_fp32(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] man;
    logic [7:0]  e;
    sgn = {h[15], 31'b0};
    ex = h[14:10];
    man = {1'b0, h[9:0]};
    if (ex == 5'd0) begin
      if (man == '0) return sgn;
      e = 8'd113;
      while (!man[10]) begin
        man = man << 1;
        e--;
      end
      return sgn | {1'b0, e, man[9:0], 13'b0};
    end
    if (ex == 5'd31) return sgn | FpInf | {9'b0, man[9:0], 13'b0};
    return sgn | {1'b0, 8'(ex + 8'd112), man[9:0], 13'b0};
  endfunction

  function automatic logic [31:0] double_to_fp32(logic [63:0] d);
    logic [31:0] sgn;
    int          ex;
    int          fe;
    int          shift;
    logic [63:0] man;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] r;
    sgn = {d[63], 31'b0};
    ex = int'(d[62:52]);
    man = {12'b0, d[51:0]};
    if (ex == 2047) begin
      if (man == '0) return sgn | FpInf;
      return sgn | FpQnan | 32'(man >> 29);
    end
    if (ex == 0) return sgn;
    fe = ex - 1023 + 127;
    if (fe > 254) return sgn | FpInf;
    sig = man | (64'b1 << 52);
    shift = (fe >= 1) ? 29 : 30 - fe;
    if (shift > 54) return sgn;
    q = sig >> shift;
    rem = sig & ((64'b1 << shift) - 1);
    half = 64'b1 << (shift - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (fe >= 1) begin
      r = (64'(fe - 1) << 23) + q;
      if (r >= 64'(FpInf)) return sgn | FpInf;
      return sgn | r[31:0];
    end
    return sgn | q[31:0];
  endfunction

  function automatic logic [31:0] component_to_fp32(logic [3:0] fmt, logic nrm,
                                                    logic [63:0] raw);
    logic         s;
    logic [127:0] mag;
    case (fmt)
      FmtS8: begin
        s = raw[7];
        mag = s ? 128'(9'd256 - raw[7:0]) : 128'(raw[7:0]);
        if (!nrm) return round_pack(s, mag, 0, 1'b0);
        if (mag == 128) return {1'b1, 31'(FpOne)};   // clamp at -1.0
        return div_round(s, mag, 128'd127);
      end
      FmtU8: return nrm ? div_round(1'b0, 128'(raw[7:0]), 128'd255)
                        : round_pack(1'b0, 128'(raw[7:0]), 0, 1'b0);
      FmtS16: begin
        s = raw[15];
        mag = s ? 128'(17'd65536 - raw[15:0]) : 128'(raw[15:0]);
        if (!nrm) return round_pack(s, mag, 0, 1'b0);
        if (mag == 32768) return {1'b1, 31'(FpOne)};
        return div_round(s, mag, 128'd32767);
      end
      FmtU16: return nrm ? div_round(1'b0, 128'(raw[15:0]), 128'd65535)
                         : round_pack(1'b0, 128'(raw[15:0]), 0, 1'b0);
      FmtHalf: return half_to_fp32(raw[15:0]);
      FmtFloat: return raw[31:0];
      FmtS32: begin
        // divisor is exactly 2^31, so scaling the rounded int is exact
        s = raw[31];
        mag = s ? 128'(33'h1_0000_0000 - raw[31:0]) : 128'(raw[31:0]);
        return round_pack(s, mag, nrm ? -31 : 0, 1'b0);
      end
      FmtU32: return round_pack(1'b0, 128'(raw[31:0]), nrm ? -32 : 0, 1'b0);
      FmtDouble: return double_to_fp32(raw);
      default: return 32'h0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    vac_out_t want;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", rsp_o.float_bits, 32'h0);
      end else begin
        want = pending_q.pop_front();
        if (rsp_o.float_bits !== want.float_bits)
          report_mismatch("float_bits", rsp_o.float_bits, want.float_bits);
        if (rsp_o.row_end !== want.row_end)
          report_mismatch("row_end", 32'(rsp_o.row_end), 32'(want.row_end));
      end
    end
  end

  task automatic send_component(logic [63:0] bits, logic last);
    vac_out_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{component_bits: bits, last_in_row: last};
    do @(posedge clk_i); while (busy);
    want.float_bits = component_to_fp32(fmt_reg, nrm_reg, bits);
    want.row_end = last;
    pending_q = {pending_q, want};
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegFormat) fmt_reg = data[3:0];
    else if (idx == RegNormalize) nrm_reg = data[0];
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(logic [3:0] fmt, logic nrm);
    write_reg(RegFormat, {4'($urandom), fmt});
    write_reg(RegNormalize, {7'($urandom), nrm});
  endtask

  task automatic test_directed;
    send_component(64'h0000_0000_3F80_0000, 1'b1);   // reset mode is float
    set_mode(FmtS8, 1'b1);
    send_component(64'h80, 1'b0);
    send_component(64'h81, 1'b0);
    send_component(64'h7F, 1'b1);
    send_component(64'hFFFF_FFFF_FFFF_FF00, 1'b0);    // high bits ignored
    set_mode(FmtU8, 1'b1);
    send_component(64'hFF, 1'b1);
    send_component(64'h01, 1'b0);
    set_mode(FmtS16, 1'b1);
    send_component(64'h8000, 1'b0);
    set_mode(FmtU16, 1'b0);
    send_component(64'hFFFF, 1'b1);
    set_mode(FmtHalf, 1'b1);                           // normalize has no effect
    send_component(64'h0001, 1'b0);
    send_component(64'h7C00, 1'b0);
    send_component(64'hFE01, 1'b1);
    send_component(64'hFFFF_FFFF_FFFF_3C00, 1'b0);
    set_mode(FmtS32, 1'b0);
    send_component(64'h8000_0000, 1'b0);
    send_component(64'h7FFF_FFFF, 1'b1);
    set_mode(FmtS32, 1'b1);
    send_component(64'h8000_0000, 1'b0);
    set_mode(FmtU32, 1'b1);
    send_component(64'hFFFF_FFFF, 1'b1);
    set_mode(FmtDouble, 1'b0);
    send_component(64'h7FF0_0000_0000_0000, 1'b0);
    send_component(64'hFFF8_0000_0000_0001, 1'b0);
    send_component(64'h47F0_0000_0000_0000, 1'b0);    // overflows to inf
    send_component(64'h0000_0000_0000_0001, 1'b0);
    send_component(64'h36A0_0000_0000_0000, 1'b0);    // smallest fp32 subnormal
    send_component(64'h3FF0_0000_1000_0000, 1'b1);    // halfway tie
    set_mode(FmtUnsupported, 1'b0);
    send_component(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    write_reg(RegFirstUnused + 4'($urandom_range(0, 13)), 8'($urandom));
    set_mode(4'hF, 1'b1);
    send_component(64'h1234, 1'b1);
  endtask

  task automatic test_random;
    logic [63:0] bits;
    logic [3:0]  fmt;
    for (int phase = 0; phase < 18; phase++) begin
      idle_on = (phase < 15);
      fmt = (phase < 16) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
      if ($urandom_range(0, 3) == 0)
        write_reg(RegFirstUnused + 4'($urandom_range(0, 13)), 8'($urandom));
      set_mode(fmt, 1'($urandom));
      for (int k = 0; k < 30; k++) begin
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0: bits = bits & 64'h3;                                // near zero
          1: bits[62:52] = 11'($urandom_range(1023 - 160, 1023 + 130));
          2: bits[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'd31;   // half special
          3: bits[62:52] = $urandom_range(0, 1) ? 11'd0 : 11'h7FF;
          default: ;
        endcase
        send_component(bits, 1'($urandom));
      end
    end
  endtask

  initial begin
    fmt_reg = FmtFloat;
    nrm_reg = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/vac_pkg.sv
hw/rtl/vac_decode.sv
hw/rtl/vac_align.sv
hw/rtl/vac_round.sv
hw/rtl/vertex_attribute_convert.sv
hw/rtl/vac_checker.sv
sim/vertex_attribute_convert_test.sv
